// File: rtl/hcb_pkg.sv
package hcb_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int HOLD_DEPTH_DEF = 32;

  localparam int BS_W   = 4;   // block size register and letter count
  localparam int ROW_W  = 4;   // key row index, covers the full MAX_DIM range
  localparam int LTR_W  = 5;   // letter number 0..25
  localparam int PROD_W = 10;  // key entry times letter, plus a residue

  localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 4'd2;

  localparam logic [7:0] CHAR_UA  = 8'h41;
  localparam logic [7:0] CHAR_UZ  = 8'h5a;
  localparam logic [7:0] CHAR_LA  = 8'h61;
  localparam logic [7:0] CHAR_LZ  = 8'h7a;
  localparam logic [7:0] CASE_GAP = 8'd32;

  localparam logic [4:0] MOD_26 = 5'd26;

  // floor(x / 26) == (x * 2521) >> 16 for every x below 1024
  localparam int RECIP_26 = 2521;
  localparam int RECIP_SH = 16;

  localparam int SLOT_BIT = 8;   // hold entry marks a letter slot

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_MAC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [ROW_W-1:0] row;
  } mac_req_t;

  typedef struct packed {
    logic             done;
    logic [LTR_W-1:0] value;
  } mac_rsp_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic logic [4:0] mod26(input logic [PROD_W-1:0] x);
    logic [21:0]       p;
    logic [5:0]        q;
    logic [PROD_W-1:0] r;
    p = 22'(x) * 22'(RECIP_26);
    q = p[21:RECIP_SH];
    r = x - PROD_W'(q) * PROD_W'(MOD_26);
    return r[4:0];
  endfunction

  function automatic logic [4:0] key_mod(input logic [4:0] v);
    return (v >= MOD_26) ? v - MOD_26 : v;
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return (ch >= CHAR_UA && ch <= CHAR_UZ) || (ch >= CHAR_LA && ch <= CHAR_LZ);
  endfunction

  function automatic logic [LTR_W-1:0] letter_num(input logic [7:0] ch);
    logic [7:0] up;
    up = (ch >= CHAR_LA) ? ch - CASE_GAP : ch;
    return LTR_W'(up - CHAR_UA);
  endfunction

endpackage

// File: rtl/hcb_if.sv
interface hcb_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_in;
  logic [2:0] key_row;
  logic [2:0] key_col;
  logic [4:0] key_value;

  modport source (output valid, mode, char_in, key_row, key_col, key_value, input ready);
  modport sink   (input valid, mode, char_in, key_row, key_col, key_value, output ready);
endinterface

interface hcb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;
  logic       status;

  modport source (output valid, char_out, last, status, input ready);
  modport sink   (input valid, char_out, last, status, output ready);
endinterface

interface hcb_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/hill_cipher_block_encrypt.sv
// Key write: no result. Non-letter with no open block: result valid in the cycle after
// the request. Completing letter: each held byte is replayed as it was and each held
// letter slot as one row result, then the closing letter's row follows (the row
// multiply-accumulate reads one key entry per cycle). One request at a time; a stalled
// output holds the replay. Reset clears the letter and hold counts and sets block_size
// to 2; key store and hold buffer contents stay undefined until written.
module hill_cipher_block_encrypt #(
  parameter int MAX_DIM    = hcb_pkg::MAX_DIM_DEF,
  parameter int HOLD_DEPTH = hcb_pkg::HOLD_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  hcb_in_if.sink       in_ch,
  hcb_out_if.source    out_ch,
  hcb_cfg_if.sink      cfg_ch
);

  localparam int KEY_DEPTH = MAX_DIM * MAX_DIM;
  localparam int KA_W      = hcb_pkg::addr_w(KEY_DEPTH);
  localparam int HA_W      = hcb_pkg::addr_w(HOLD_DEPTH);
  localparam int HC_W      = $clog2(HOLD_DEPTH + 1);
  localparam int SUM_W     = HC_W + 1;
  localparam int LI_W      = hcb_pkg::addr_w(MAX_DIM);
  localparam int BS_W      = hcb_pkg::BS_W;
  localparam int ROW_W     = hcb_pkg::ROW_W;

  hcb_pkg::state_t state_r, state_nxt;

  logic [BS_W-1:0]  bs_r, bs_nxt;
  logic [BS_W-1:0]  lc_r, lc_nxt;
  logic [HC_W-1:0]  hc_r, hc_nxt;
  logic [HC_W-1:0]  rp_n_r, rp_n_nxt;
  logic [HC_W-1:0]  idx_r, idx_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             fin_r, fin_nxt;
  logic [7:0]       em_char_r, em_char_nxt;
  logic             em_last_r, em_last_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r;
  logic             out_last_r;
  logic             out_status_r;
  logic             out_load;
  logic [7:0]       out_char_nxt;
  logic             out_last_nxt;
  logic             out_status_nxt;
  logic             out_free;

  logic [MAX_DIM-1:0][hcb_pkg::LTR_W-1:0] letters_r;
  logic             letter_wr;

  logic [BS_W-1:0]  n_eff;
  logic [BS_W-1:0]  n_m1;
  logic [BS_W-1:0]  lc_p1;
  logic [BS_W-1:0]  pending;
  logic [SUM_W-1:0] need;
  logic             in_fire;
  logic             cfg_fire;
  logic             ch_letter;
  logic             blk_done;

  logic             key_we;
  logic [KA_W-1:0]  key_waddr;
  logic [4:0]       key_wdata;
  logic             key_re;
  logic [KA_W-1:0]  key_raddr;
  logic [4:0]       key_rdata;

  logic             hold_we;
  logic [8:0]       hold_wdata;
  logic             hold_re;
  logic [8:0]       hold_rdata;

  hcb_pkg::mac_req_t mac_req;
  hcb_pkg::mac_rsp_t mac_rsp;

  assign n_eff = (bs_r == '0) ? BS_W'(1) :
                 (bs_r > BS_W'(MAX_DIM)) ? BS_W'(MAX_DIM) : bs_r;
  assign n_m1    = n_eff - BS_W'(1);
  assign lc_p1   = lc_r + BS_W'(1);
  assign pending = (n_m1 > lc_r) ? n_m1 - lc_r : '0;
  assign need    = SUM_W'(hc_r) + SUM_W'(1) + SUM_W'(pending);

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == hcb_pkg::ST_IDLE) && out_free;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign ch_letter    = hcb_pkg::is_letter(in_ch.char_in);
  assign letter_wr    = in_fire && !in_ch.mode && ch_letter;
  assign blk_done     = letter_wr && !(lc_p1 < n_eff);

  assign key_waddr  = KA_W'(int'(in_ch.key_row) * MAX_DIM + int'(in_ch.key_col));
  assign key_wdata  = hcb_pkg::key_mod(in_ch.key_value);

  always_comb begin
    state_nxt      = state_r;
    bs_nxt         = bs_r;
    lc_nxt         = lc_r;
    hc_nxt         = hc_r;
    rp_n_nxt       = rp_n_r;
    idx_nxt        = idx_r;
    row_nxt        = row_r;
    fin_nxt        = fin_r;
    em_char_nxt    = em_char_r;
    em_last_nxt    = em_last_r;
    out_load       = 1'b0;
    out_char_nxt   = in_ch.char_in;
    out_last_nxt   = 1'b1;
    out_status_nxt = 1'b0;
    key_we         = 1'b0;
    hold_we        = 1'b0;
    hold_wdata     = {1'b0, in_ch.char_in};
    hold_re        = 1'b0;
    mac_req.start  = 1'b0;
    mac_req.row    = ROW_W'(n_m1);

    unique case (state_r)
      hcb_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.mode) begin
            key_we = (int'(in_ch.key_row) < MAX_DIM) && (int'(in_ch.key_col) < MAX_DIM);
          end else if (ch_letter) begin
            if (lc_p1 < n_eff) begin
              lc_nxt = lc_p1;
              if (hc_r < HC_W'(HOLD_DEPTH)) begin
                hold_we    = 1'b1;
                hold_wdata = 9'(1) << hcb_pkg::SLOT_BIT;
                hc_nxt     = hc_r + HC_W'(1);
              end
            end else begin
              lc_nxt   = '0;
              hc_nxt   = '0;
              rp_n_nxt = hc_r;
              idx_nxt  = '0;
              row_nxt  = '0;
              if (hc_r != '0) begin
                state_nxt = hcb_pkg::ST_RD;
              end else begin
                mac_req.start = 1'b1;
                fin_nxt       = 1'b1;
                state_nxt     = hcb_pkg::ST_MAC;
              end
            end
          end else if (lc_r == '0) begin
            out_load = 1'b1;
          end else if (need <= SUM_W'(HOLD_DEPTH - 1)) begin
            hold_we = 1'b1;
            hc_nxt  = hc_r + HC_W'(1);
          end else begin
            out_load       = 1'b1;
            out_status_nxt = 1'b1;
          end
        end
      end
      hcb_pkg::ST_RD: begin
        hold_re   = 1'b1;
        state_nxt = hcb_pkg::ST_CHK;
      end
      hcb_pkg::ST_CHK: begin
        if (hold_rdata[hcb_pkg::SLOT_BIT]) begin
          mac_req.start = 1'b1;
          mac_req.row   = row_r;
          row_nxt       = row_r + ROW_W'(1);
          fin_nxt       = 1'b0;
          state_nxt     = hcb_pkg::ST_MAC;
        end else begin
          em_char_nxt = hold_rdata[7:0];
          em_last_nxt = 1'b0;
          state_nxt   = hcb_pkg::ST_EMIT;
        end
      end
      hcb_pkg::ST_MAC: begin
        if (mac_rsp.done) begin
          em_char_nxt = hcb_pkg::CHAR_UA + 8'(mac_rsp.value);
          em_last_nxt = fin_r;
          state_nxt   = hcb_pkg::ST_EMIT;
        end
      end
      hcb_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_char_nxt = em_char_r;
          out_last_nxt = em_last_r;
          if (em_last_r) begin
            state_nxt = hcb_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r + HC_W'(1);
            if (idx_r + HC_W'(1) < rp_n_r) begin
              state_nxt = hcb_pkg::ST_RD;
            end else begin
              mac_req.start = 1'b1;
              fin_nxt       = 1'b1;
              state_nxt     = hcb_pkg::ST_MAC;
            end
          end
        end
      end
      default: begin
        state_nxt = hcb_pkg::ST_IDLE;
      end
    endcase

    // a block size write abandons the open block
    if (cfg_fire) begin
      bs_nxt = cfg_ch.data;
      lc_nxt = '0;
      hc_nxt = '0;
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcb_pkg::ST_IDLE;
      bs_r        <= hcb_pkg::BLOCK_SIZE_RST;
      lc_r        <= '0;
      hc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bs_r        <= bs_nxt;
      lc_r        <= lc_nxt;
      hc_r        <= hc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_n_r    <= rp_n_nxt;
    idx_r     <= idx_nxt;
    row_r     <= row_nxt;
    fin_r     <= fin_nxt;
    em_char_r <= em_char_nxt;
    em_last_r <= em_last_nxt;
    if (letter_wr) begin
      letters_r[lc_r[LI_W-1:0]] <= hcb_pkg::letter_num(in_ch.char_in);
    end
    if (out_load) begin
      out_char_r   <= out_char_nxt;
      out_last_r   <= out_last_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.status   = out_status_r;

  hcb_ram #(
    .WIDTH (5),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  hcb_ram #(
    .WIDTH (9),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_ram (
    .clk   (clk),
    .we    (hold_we),
    .waddr (hc_r[HA_W-1:0]),
    .wdata (hold_wdata),
    .re    (hold_re),
    .raddr (idx_r[HA_W-1:0]),
    .rdata (hold_rdata)
  );

  hcb_row_mac #(
    .MAX_DIM (MAX_DIM)
  ) u_row_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mac_req),
    .n         (n_eff),
    .letters   (letters_r),
    .key_re    (key_re),
    .key_raddr (key_raddr),
    .key_rdata (key_rdata),
    .rsp       (mac_rsp)
  );

  a_done_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    mac_rsp.done |-> state_r == hcb_pkg::ST_MAC)
    else $error("row result outside of accumulate wait");

  a_lc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lc_r < n_eff)
    else $error("letter count reached block size");

  a_no_hold_closed: assert property (@(posedge clk) disable iff (!rst_n)
    lc_r == '0 |-> hc_r == '0)
    else $error("held entries with no open block");

  a_blk_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    blk_done && !cfg_fire |=> state_r != hcb_pkg::ST_IDLE)
    else $error("completed block did not start replay");

endmodule

// File: rtl/hcb_ram.sv
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [hcb_pkg::addr_w(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]                   wdata,
  input  logic                               re,
  input  logic [hcb_pkg::addr_w(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/hcb_row_mac.sv
module hcb_row_mac #(
  parameter int MAX_DIM = hcb_pkg::MAX_DIM_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  hcb_pkg::mac_req_t                          req,
  input  logic [hcb_pkg::BS_W-1:0]                   n,
  input  logic [MAX_DIM-1:0][hcb_pkg::LTR_W-1:0]     letters,
  output logic                                       key_re,
  output logic [hcb_pkg::addr_w(MAX_DIM*MAX_DIM)-1:0] key_raddr,
  input  logic [hcb_pkg::LTR_W-1:0]                  key_rdata,
  output hcb_pkg::mac_rsp_t                          rsp
);

  localparam int KEY_DEPTH = MAX_DIM * MAX_DIM;
  localparam int KA_W      = hcb_pkg::addr_w(KEY_DEPTH);
  localparam int LI_W      = hcb_pkg::addr_w(MAX_DIM);

  logic                       issue_r;
  logic                       v1_r;
  logic                       v2_r;
  logic                       done_r;
  logic [hcb_pkg::BS_W-1:0]   c_r;
  logic [hcb_pkg::ROW_W-1:0]  row_r;
  logic                       l1_r;
  logic                       l2_r;
  logic [LI_W-1:0]            lidx_r;
  logic [hcb_pkg::PROD_W-1:0] prod_r;
  logic [hcb_pkg::LTR_W-1:0]  acc_r;
  logic                       c_last;

  assign c_last    = (c_r == n - hcb_pkg::BS_W'(1));
  assign key_re    = issue_r;
  assign key_raddr = KA_W'(int'(row_r) * MAX_DIM + int'(c_r));

  // issue -> key data -> product -> accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      if (req.start) begin
        issue_r <= 1'b1;
      end else if (issue_r && c_last) begin
        issue_r <= 1'b0;
      end
      v1_r   <= issue_r;
      v2_r   <= v1_r;
      done_r <= v2_r && l2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      c_r   <= '0;
      row_r <= req.row;
      acc_r <= '0;
    end else begin
      if (issue_r) begin
        c_r <= c_r + hcb_pkg::BS_W'(1);
      end
      if (v2_r) begin
        acc_r <= hcb_pkg::mod26(hcb_pkg::PROD_W'(acc_r) + prod_r);
      end
    end
    l1_r   <= c_last;
    lidx_r <= c_r[LI_W-1:0];
    if (v1_r) begin
      prod_r <= hcb_pkg::PROD_W'(key_rdata) * hcb_pkg::PROD_W'(letters[lidx_r]);
      l2_r   <= l1_r;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = acc_r;

endmodule

// File: tb/hcb_tb_pkg.sv
package hcb_tb_pkg;

  typedef enum logic {
    MODE_TEXT = 1'b0,
    MODE_KEY  = 1'b1
  } req_mode_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_DROPPED = 1'b1
  } char_status_e;

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= hcb_pkg::CHAR_UA && ch <= hcb_pkg::CHAR_UZ) ||
           (ch >= hcb_pkg::CHAR_LA && ch <= hcb_pkg::CHAR_LZ);
  endfunction

  // block size register as the block sees it: 0 means 1, clipped at MAX_DIM
  function automatic int unsigned eff_dim(input logic [3:0] size);
    if (size == 0) return 1;
    if (size > hcb_pkg::MAX_DIM_DEF) return hcb_pkg::MAX_DIM_DEF;
    return size;
  endfunction

endpackage

// File: tb/hcb_cipher_checker.sv
module hcb_cipher_checker (
  input  logic clk,
  input  logic rst_n,
  hcb_in_if    in_ch,
  hcb_out_if   out_ch,
  hcb_cfg_if   cfg_ch,
  output int   mismatches,
  output int   awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM  = hcb_pkg::MAX_DIM_DEF;
  localparam int HOLD = hcb_pkg::HOLD_DEPTH_DEF;
  localparam logic [8:0] LETTER_SLOT = 9'(1) << hcb_pkg::SLOT_BIT;

  typedef struct packed {
    logic [7:0]               char_out;
    logic                     last;
    hcb_tb_pkg::char_status_e status;
  } cipher_char_t;

  logic [4:0]   key_mat [DIM*DIM];
  logic [4:0]   blk_ltr [DIM];
  logic [8:0]   hold_buf [HOLD];
  int unsigned  ltr_cnt;
  int unsigned  hold_cnt;
  logic [3:0]   blk_size;
  cipher_char_t cipher_q [$];

  function automatic logic [4:0] row_sum(input int unsigned r, input int unsigned n);
    int unsigned acc;
    int unsigned c;
    acc = 0;
    for (c = 0; c < n; c++) acc += key_mat[r*DIM + c] * blk_ltr[c];
    return 5'(acc % hcb_pkg::MOD_26);
  endfunction

  function automatic void model_req(input logic mode, input logic [7:0] ch,
                                    input logic [2:0] row, input logic [2:0] col,
                                    input logic [4:0] kval);
    int unsigned n;
    int unsigned i;
    int unsigned r;
    int unsigned need;
    logic [7:0]  up;
    n = hcb_tb_pkg::eff_dim(blk_size);
    if (mode == hcb_tb_pkg::MODE_KEY) begin
      key_mat[row*DIM + col] = 5'(kval % hcb_pkg::MOD_26);
      return;
    end
    if (hcb_tb_pkg::is_alpha(ch)) begin
      up = (ch >= hcb_pkg::CHAR_LA) ? ch - hcb_pkg::CASE_GAP : ch;
      if (ltr_cnt < DIM) blk_ltr[ltr_cnt] = 5'(up - hcb_pkg::CHAR_UA);
      ltr_cnt++;
      if (ltr_cnt < n) begin
        if (hold_cnt < HOLD) begin
          hold_buf[hold_cnt] = LETTER_SLOT;
          hold_cnt++;
        end
        return;
      end
      // block complete: replay held entries, letter slots take rows in order
      r = 0;
      for (i = 0; i < hold_cnt; i++) begin
        if (hold_buf[i][hcb_pkg::SLOT_BIT]) begin
          cipher_q.push_back('{8'(hcb_pkg::CHAR_UA + row_sum(r, n)), 1'b0,
                               hcb_tb_pkg::STATUS_OK});
          r++;
        end else begin
          cipher_q.push_back('{hold_buf[i][7:0], 1'b0, hcb_tb_pkg::STATUS_OK});
        end
      end
      cipher_q.push_back('{8'(hcb_pkg::CHAR_UA + row_sum(n - 1, n)), 1'b1,
                           hcb_tb_pkg::STATUS_OK});
      ltr_cnt  = 0;
      hold_cnt = 0;
      return;
    end
    if (ltr_cnt == 0) begin
      cipher_q.push_back('{ch, 1'b1, hcb_tb_pkg::STATUS_OK});
      return;
    end
    // keep room for the slots of letters still to come, the closing one excluded
    need = (n - 1 > ltr_cnt) ? n - 1 - ltr_cnt : 0;
    if (hold_cnt + 1 + need <= HOLD - 1) begin
      hold_buf[hold_cnt] = {1'b0, ch};
      hold_cnt++;
    end else begin
      cipher_q.push_back('{ch, 1'b1, hcb_tb_pkg::STATUS_DROPPED});
    end
  endfunction

  always @(posedge clk) begin
    cipher_char_t want;
    if (!rst_n) begin
      ltr_cnt    = 0;
      hold_cnt   = 0;
      blk_size   = hcb_pkg::BLOCK_SIZE_RST;
      mismatches = 0;
      cipher_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        blk_size = cfg_ch.data;
        ltr_cnt  = 0;
        hold_cnt = 0;
      end
      if (in_ch.valid && in_ch.ready)
        model_req(in_ch.mode, in_ch.char_in, in_ch.key_row, in_ch.key_col, in_ch.key_value);
      if (out_ch.valid && out_ch.ready) begin
        if (cipher_q.size() == 0) begin
          $error("unexpected result: char_out %02h last %0d status %0d",
                 out_ch.char_out, out_ch.last, out_ch.status);
          mismatches++;
        end else begin
          want = cipher_q.pop_front();
          if (out_ch.char_out !== want.char_out) begin
            $error("char_out: expected %02h, actual %02h", want.char_out, out_ch.char_out);
            mismatches++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_ch.last);
            mismatches++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_ch.status);
            mismatches++;
          end
        end
      end
    end
    awaiting = cipher_q.size();
  end

endmodule

// File: tb/hill_cipher_block_encrypt_tb.sv
module hill_cipher_block_encrypt_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 8;
  localparam int FLOOD_PHASE   = 1;
  localparam int DRAIN_CYCLES  = 20;
  localparam int STALL_AT      = 40;
  localparam int STALL_CYCLES  = 300;
  localparam int QUIET_LIMIT   = 2000;

  // extremes first, then the out-of-range encodings
  localparam logic [3:0] SIZE_PLAN [PHASES] =
    '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd6, 4'd2};

  logic clk;
  logic rst_n;
  int   mismatches;
  int   awaiting;
  int   src_calm;
  int   snk_calm;

  hcb_in_if  in_bus ();
  hcb_out_if out_bus ();
  hcb_cfg_if cfg_bus ();

  hill_cipher_block_encrypt uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  hcb_cipher_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .cfg_ch     (cfg_bus),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random idle gap before each request, with occasional runs of back-to-back traffic
  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 30);
      gap = $urandom_range(0, 3);
    end
  endtask

  task automatic send_req(input hcb_tb_pkg::req_mode_e mode, input logic [7:0] ch,
                          input logic [2:0] row, input logic [2:0] col,
                          input logic [4:0] kval);
    int gap;
    draw_gap(src_calm, gap);
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid     <= 1'b1;
    in_bus.mode      <= mode;
    in_bus.char_in   <= ch;
    in_bus.key_row   <= row;
    in_bus.key_col   <= col;
    in_bus.key_value <= kval;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_req(hcb_tb_pkg::MODE_TEXT, ch, 3'($urandom), 3'($urandom), 5'($urandom));
  endtask

  task automatic send_key(input logic [2:0] row, input logic [2:0] col, input logic [4:0] kval);
    send_req(hcb_tb_pkg::MODE_KEY, 8'($urandom), row, col, kval);
  endtask

  task automatic write_block_size(input logic [3:0] size);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= size;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // drop the request line and let every expected character come out
  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] ch;
    ch = 8'(hcb_pkg::CHAR_UA + $urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) ch = ch + hcb_pkg::CASE_GAP;
    return ch;
  endfunction

  function automatic logic [7:0] rand_other();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (hcb_tb_pkg::is_alpha(ch));
    return ch;
  endfunction

  // mostly complete blocks with punctuation mixed in, plus key updates and noise
  task automatic run_text(input int unsigned n, input int unsigned quota);
    int unsigned sent;
    int unsigned kind;
    int unsigned i;
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_key(3'($urandom), 3'($urandom), 5'($urandom));
        sent++;
      end else if (kind < 78) begin
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            send_char(rand_other());
            sent++;
          end
          send_char(rand_letter());
          sent++;
        end
      end else begin
        send_char(8'($urandom));
        sent++;
      end
    end
  endtask

  // open a block and keep feeding non-letters until the hold buffer overflows
  task automatic flood_block();
    int unsigned len;
    len = $urandom_range(28, 34);
    send_char(rand_letter());
    repeat (len) send_char(rand_other());
    send_char(rand_letter());
  endtask

  initial begin
    int gap;
    int taken;
    out_bus.ready = 1'b0;
    taken = 0;
    forever begin
      draw_gap(snk_calm, gap);
      repeat (gap) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
      end
      @(negedge clk);
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      taken++;
      // long back-pressure so the block stalls its input
      if (taken == STALL_AT) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int p;
    int r;
    int c;
    rst_n            = 1'b0;
    src_calm         = 0;
    snk_calm         = 0;
    in_bus.valid     = 1'b0;
    in_bus.mode      = hcb_tb_pkg::MODE_TEXT;
    in_bus.char_in   = 8'h00;
    in_bus.key_row   = 3'd0;
    in_bus.key_col   = 3'd0;
    in_bus.key_value = 5'd0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.data     = 4'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // whole key matrix first, so no block ever reads an unwritten entry
    for (r = 0; r < hcb_pkg::MAX_DIM_DEF; r++)
      for (c = 0; c < hcb_pkg::MAX_DIM_DEF; c++)
        send_key(3'(r), 3'(c), 5'($urandom_range(0, 31)));

    // directed, reset block size of 2
    send_char(8'h00);
    send_char(8'hff);
    send_char(8'h40);
    send_char(8'h5b);
    send_char(8'h60);
    send_char(8'h7b);
    send_char("A");
    send_char("z");
    send_char("a");
    send_char(",");
    send_char("Z");
    send_char("Q");
    send_char(8'h80);
    send_char(8'h7f);
    send_char("m");
    send_key(3'd0, 3'd0, 5'd31);
    send_key(3'd7, 3'd7, 5'd26);
    send_key(3'd1, 3'd1, 5'd25);
    send_key(3'd0, 3'd1, 5'd0);
    send_char("b");
    send_char("C");
    send_char("Y");
    send_char(" ");
    send_char("y");

    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      write_block_size(SIZE_PLAN[p]);
      run_text(hcb_tb_pkg::eff_dim(SIZE_PLAN[p]), PHASE_ITEMS);
      // largest block leaves the least room, so the flood overflows there
      if (p == FLOOD_PHASE) flood_block();
      // leave a block open, where a block holds more than one letter, so the next size write has to abandon it
      send_char(rand_letter());
    end

    wait_idle();
    repeat (40) @(negedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
